// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the frame admission monitor.
// Needs no other file; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define FAM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("fam assertion failed");

// Condition in one cycle implies a consequence in the next.
`define FAM_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("fam assertion failed");

`endif

// File: rtl/core/fam_pkg.sv
// Types, codes and defaults of the frame admission and sequence gap monitor.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package fam_pkg;

	// Default sizes
	localparam int FAM_TOPIC_COUNT = 256;
	localparam int FAM_QUEUE_SLOTS = 256;
	localparam int FAM_LENGTH_BITS = 16;

	// Range of the stream_id field
	localparam int TOPIC_ID_RANGE = 256;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd1;

	localparam logic [7:0]  QUEUE_LIMIT_RST   = 8'd32;
	localparam logic [15:0] WINDOW_LENGTH_RST = 16'd100;

	// Event codes
	localparam logic [1:0] REQ_ARRIVAL = 2'd0;
	localparam logic [1:0] REQ_SEND    = 2'd1;
	localparam logic [1:0] REQ_STATUS  = 2'd2;

	// Congestion codes
	localparam logic [1:0] MEDIUM_DOWN       = 2'd0;
	localparam logic [1:0] MEDIUM_OK         = 2'd1;
	localparam logic [1:0] MEDIUM_CONGESTED  = 2'd2;
	localparam logic [1:0] MEDIUM_OVERLOADED = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} fam_state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  stream_id;
		logic [7:0]  seq_number;
		logic [15:0] frame_bytes;
		logic        link_ready;
	} req_item_t;

	typedef struct packed {
		logic        frame_accepted;
		logic        frame_dropped;
		logic [7:0]  gap_missing;
		logic        sent_valid;
		logic [15:0] sent_bytes;
		logic [7:0]  fifo_depth;
		logic [31:0] drops_in_window;
		logic [7:0]  gaps_in_window;
		logic [31:0] bytes_in_window;
		logic [1:0]  cong_state;
		logic [15:0] window_echo;
	} rsp_item_t;

endpackage

`default_nettype wire

// File: rtl/core/fam_req_if.sv
// Event channel of the frame admission monitor: valid/ready plus one event.
// Depends on fam_pkg for the payload type.
`default_nettype none

interface fam_req_if
	import fam_pkg::*;
();
	logic      valid;
	logic      ready;
	req_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fam_rsp_if.sv
// Result channel of the frame admission monitor: valid/ready plus one result.
// Depends on fam_pkg for the payload type.
`default_nettype none

interface fam_rsp_if
	import fam_pkg::*;
();
	logic      valid;
	logic      ready;
	rsp_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/core/frame_admission_and_seq_gap_monitor.sv
// Frame admission and sequence gap monitor. The per-topic sequence memory and
// the length FIFO memory are read when an event is accepted; in ST_EXEC the
// result is formed and the memories written back once the output register is
// empty or being taken. One result transaction per event; a finished result
// waits in an output register. After reset a clearing pass over every topic
// wipes the sequence memory before the first event is taken; configuration
// writes are to be made only while the block is idle; the block does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module frame_admission_and_seq_gap_monitor
	import fam_pkg::*;
#(
	parameter int TOPIC_COUNT = FAM_TOPIC_COUNT,
	parameter int QUEUE_SLOTS = FAM_QUEUE_SLOTS,
	parameter int LENGTH_BITS = FAM_LENGTH_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fam_req_if.sink                    req,
	fam_rsp_if.source                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TOPIC_W = $clog2(TOPIC_COUNT);
	localparam int PTR_W   = $clog2(QUEUE_SLOTS);
	localparam int CNT_W   = $clog2(QUEUE_SLOTS + 1);
	localparam int CMP_W   = 10;
	localparam int SEQ_W   = 9;

	// stream_id folded onto the table size
	logic [TOPIC_W-1:0] fold_tbl [TOPIC_ID_RANGE];
	for (genvar g = 0; g < TOPIC_ID_RANGE; g++) begin : g_fold
		assign fold_tbl[g] = TOPIC_W'(g % TOPIC_COUNT);
	end

	// Memories: {seen, last sequence} per topic, and queued lengths
	logic [SEQ_W-1:0]       seq_mem [TOPIC_COUNT];
	logic [LENGTH_BITS-1:0] len_mem [QUEUE_SLOTS];

	fam_state_t state_q, state_nx;
	logic [TOPIC_W-1:0] clr_q;
	logic               accept, commit, clr_we, rsp_valid_q;

	logic [7:0]  limit_q;
	logic [15:0] window_q;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q, count_nx;
	logic [31:0] drop_cnt_q, byte_cnt_q;
	logic [7:0]  gap_cnt_q;

	req_item_t              item_s1;
	logic [TOPIC_W-1:0]     topic_s1;
	logic [SEQ_W-1:0]       seq_rd_s1;
	logic [LENGTH_BITS-1:0] len_rd_s1;
	rsp_item_t              rsp_q, rsp_nx;

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nx  = state_q;
		req.ready = 1'b0;
		commit    = 1'b0;
		clr_we    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clr_we = 1'b1;
				if (clr_q == TOPIC_W'(TOPIC_COUNT - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!rsp_valid_q || rsp.ready) begin
					commit   = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= QUEUE_LIMIT_RST;
			window_q <= WINDOW_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUEUE_LIMIT:   limit_q  <= cfg_data[7:0];
				CFG_WINDOW_LENGTH: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: capture event and read memories
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1   <= req.payload;
			topic_s1  <= fold_tbl[req.payload.stream_id];
			seq_rd_s1 <= seq_mem[fold_tbl[req.payload.stream_id]];
			len_rd_s1 <= len_mem[head_q];
		end
	end

	// Stage 2: evaluate
	logic       is_arr, is_send, is_stat;
	logic       seen, mismatch, drop, push, pop;
	logic [7:0] expected, gap;
	logic [8:0] gap_sum;
	logic [32:0] drop_sum, byte_sum;
	logic [11:0] d10, q8;
	logic [1:0] cong_level;

	always_comb begin
		is_arr   = item_s1.req_type == REQ_ARRIVAL;
		is_send  = item_s1.req_type == REQ_SEND;
		is_stat  = item_s1.req_type == REQ_STATUS;
		seen     = seq_rd_s1[SEQ_W-1];
		expected = seq_rd_s1[7:0] + 8'd1;
		mismatch = seen && (item_s1.seq_number != expected);
		gap      = mismatch ? (item_s1.seq_number - expected) : 8'd0;
		gap_sum  = {1'b0, gap_cnt_q} + {1'b0, gap};
		drop     = (CMP_W'(count_q) >= CMP_W'(limit_q))
			|| (CMP_W'(count_q) >= CMP_W'(QUEUE_SLOTS));
		push     = is_arr && !drop;
		pop      = is_send && (count_q != '0) && item_s1.link_ready;
		drop_sum = {1'b0, drop_cnt_q} + 33'd1;
		byte_sum = {1'b0, byte_cnt_q} + 33'(len_rd_s1);

		count_nx = count_q;
		if (push) begin
			count_nx = count_q + 1'b1;
		end else if (pop) begin
			count_nx = count_q - 1'b1;
		end

		d10 = 12'(count_q) * 12'd10;
		q8  = {1'b0, limit_q, 3'b000};
		if (!item_s1.link_ready) begin
			cong_level = MEDIUM_DOWN;
		end else if (limit_q == 8'd0) begin
			cong_level = MEDIUM_OK;
		end else if (d10 >= q8) begin
			cong_level = MEDIUM_OVERLOADED;
		end else if ((12'(count_q) << 1) >= 12'(limit_q)) begin
			cong_level = MEDIUM_CONGESTED;
		end else begin
			cong_level = MEDIUM_OK;
		end

		rsp_nx                 = '0;
		rsp_nx.frame_accepted  = push;
		rsp_nx.frame_dropped   = is_arr && drop;
		rsp_nx.gap_missing     = is_arr ? gap : 8'd0;
		rsp_nx.sent_valid      = pop;
		rsp_nx.sent_bytes      = pop ? 16'(len_rd_s1) : 16'd0;
		rsp_nx.fifo_depth      = (CMP_W'(count_nx) > CMP_W'(255)) ? 8'd255 : 8'(count_nx);
		if (is_stat) begin
			rsp_nx.drops_in_window = drop_cnt_q;
			rsp_nx.gaps_in_window  = gap_cnt_q;
			rsp_nx.bytes_in_window = byte_cnt_q;
			rsp_nx.cong_state      = cong_level;
			rsp_nx.window_echo     = window_q;
		end
	end

	// Sequence memory write port: clearing pass or arrival write-back
	always_ff @(posedge clk) begin
		if (clr_we) begin
			seq_mem[clr_q] <= '0;
		end else if (commit && is_arr) begin
			seq_mem[topic_s1] <= {1'b1, item_s1.seq_number};
		end
	end

	always_ff @(posedge clk) begin
		if (commit && push) begin
			len_mem[tail_q] <= LENGTH_BITS'(item_s1.frame_bytes);
		end
	end

	// Queue pointers and window counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			drop_cnt_q <= '0;
			gap_cnt_q  <= '0;
			byte_cnt_q <= '0;
		end else if (commit) begin
			count_q <= count_nx;
			if (push) begin
				tail_q <= (tail_q == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q     <= (head_q == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + 1'b1;
				byte_cnt_q <= byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
			end
			if (is_arr && drop) begin
				drop_cnt_q <= drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0];
			end
			if (is_arr && mismatch) begin
				gap_cnt_q <= gap_sum[8] ? 8'd255 : gap_sum[7:0];
			end
			if (is_stat) begin
				drop_cnt_q <= '0;
				gap_cnt_q  <= '0;
				byte_cnt_q <= '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	`FAM_ASSERT(a_count_bound, clk, arst_n, CMP_W'(count_q) <= CMP_W'(QUEUE_SLOTS))
	`FAM_ASSERT_NEXT(a_drop_holds_count, clk, arst_n, commit && is_arr && drop,
		$stable(count_q))
	`FAM_ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1,
		count_q == $past(count_q) || count_q == $past(count_q) + 1'b1
		|| count_q == $past(count_q) - 1'b1)
	`FAM_ASSERT(a_one_outcome, clk, arst_n,
		!(rsp.valid && rsp.payload.frame_accepted && rsp.payload.frame_dropped))

endmodule

`default_nettype wire
